>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

>>> sv/ltrie_pkg.sv
// ----------------------------------------------------------------------------
// ltrie_pkg
// Constants, codes and helpers for the lowercase trie engine.
// ----------------------------------------------------------------------------
package ltrie_pkg;

	localparam int unsigned NODE_COUNT_DEF = 1024;
	localparam int unsigned ALPHABET       = 26;

	localparam logic [7:0] LETTER_A = 8'h61;
	localparam logic [7:0] LETTER_Z = 8'h7a;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam int unsigned MODE_PREFIX_BIT = 1;

	localparam int unsigned USER_HAS_BIT = 2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	typedef enum logic [1:0] {
		FAULT_NONE,
		FAULT_INVALID,
		FAULT_FULL,
		FAULT_MISS
	} fault_t;

	function automatic logic [1:0] fault_status(fault_t f);
		logic [1:0] s;
		case (f)
			FAULT_INVALID: s = STATUS_INVALID;
			FAULT_FULL:    s = STATUS_FULL;
			default:       s = STATUS_OK;
		endcase
		return s;
	endfunction

endpackage

>>> sv/lowercase_trie_engine_core.sv
// Letter request: child-table read in IDLE, link update or allocation in LOOK.
// Last request: the result goes through FIN and EMIT, after LOOK when it
// carries a valid letter; an unfaulted whole-word search adds MREAD for the mark read.
// Result register decouples output: next request is taken while a result waits.
// Reset: child table and marks are swept to zero, one entry per cycle over
// NODE_COUNT*26 child entries (26624 at default); s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
// lowercase_trie_engine_core
// 26-way trie of lowercase words in a fixed node pool: insert, whole-word
// search and prefix search, one letter per request, result on tlast.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lowercase_trie_engine_core
	import ltrie_pkg::*;
#(
	parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] letter
	input  logic [2:0] s_tuser,   // [1:0] mode, [2] has_letter
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] found, [2:1] status, [7:3] zero
);

	localparam int unsigned NW     = $clog2(NODE_COUNT);
	localparam int unsigned FW     = $clog2(NODE_COUNT + 1);
	localparam int unsigned CDEPTH = NODE_COUNT * ALPHABET;
	localparam int unsigned AW     = $clog2(CDEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_FIN,
		ST_MREAD,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [NW-1:0] cur_q;
	logic [FW-1:0] next_free_q;
	fault_t        fault_q;
	logic [1:0]    mode_q;
	logic          last_q;
	logic [AW-1:0] slot_q;
	logic          res_found_q;
	logic [1:0]    res_status_q;
	logic          m_tvalid_q;
	logic          m_found_q;
	logic [1:0]    m_status_q;

	logic          letter_ok;
	logic          walk;
	logic [4:0]    letter_idx;
	logic [AW-1:0] child_raddr;
	logic          child_we;
	logic [AW-1:0] child_waddr;
	logic [NW-1:0] child_wdata;
	logic [NW-1:0] child_rdata;
	logic          pool_full;
	logic          clearing;
	logic          mark_we;
	logic [NW-1:0] mark_waddr;
	logic          mark_wdata;
	logic          mark_rdata;
	logic          mark_ins;

	assign clearing   = (state_q == ST_CLEAR);
	assign letter_ok  = s_tdata inside {[LETTER_A:LETTER_Z]};
	assign walk       = s_tuser[USER_HAS_BIT] && (fault_q == FAULT_NONE) && letter_ok;
	assign letter_idx = 5'(s_tdata - LETTER_A);
	assign pool_full  = (next_free_q >= FW'(NODE_COUNT));

	assign child_raddr = AW'(AW'(cur_q) * AW'(ALPHABET)) + AW'(letter_idx);

	always_comb begin
		child_we    = 1'b0;
		child_waddr = slot_q;
		child_wdata = next_free_q[NW-1:0];
		if (clearing) begin
			child_we    = 1'b1;
			child_waddr = clr_q;
			child_wdata = '0;
		end else if (state_q == ST_LOOK && child_rdata == '0 &&
				mode_q == MODE_INSERT && !pool_full) begin
			child_we = 1'b1;
		end
	end

	assign mark_ins = (state_q == ST_FIN) && (fault_q == FAULT_NONE) &&
		(mode_q == MODE_INSERT);

	always_comb begin
		mark_we    = mark_ins;
		mark_waddr = cur_q;
		mark_wdata = 1'b1;
		if (clearing) begin
			mark_we    = (clr_q < AW'(NODE_COUNT));
			mark_waddr = clr_q[NW-1:0];
			mark_wdata = 1'b0;
		end
	end

	ltrie_ram #(
		.WIDTH(NW),
		.DEPTH(CDEPTH)
	) u_child_ram (
		.clk  (clk),
		.we   (child_we),
		.waddr(child_waddr),
		.wdata(child_wdata),
		.raddr(child_raddr),
		.rdata(child_rdata)
	);

	ltrie_ram #(
		.WIDTH(1),
		.DEPTH(NODE_COUNT)
	) u_mark_ram (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(cur_q),
		.rdata(mark_rdata)
	);

	// child read is issued in IDLE, written back in LOOK; the next read cannot
	// come before the following IDLE, so no forwarding is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			cur_q        <= '0;
			next_free_q  <= FW'(1);
			fault_q      <= FAULT_NONE;
			mode_q       <= MODE_INSERT;
			last_q       <= 1'b0;
			slot_q       <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= STATUS_OK;
			m_tvalid_q   <= 1'b0;
			m_found_q    <= 1'b0;
			m_status_q   <= STATUS_OK;
		end else begin
			if (m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CDEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q <= s_tuser[1:0];
						last_q <= s_tlast;
						slot_q <= child_raddr;
						if (walk) begin
							state_q <= ST_LOOK;
						end else begin
							if (s_tuser[USER_HAS_BIT] && fault_q == FAULT_NONE) begin
								fault_q <= FAULT_INVALID;
							end
							if (s_tlast) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_LOOK: begin
					if (child_rdata == '0) begin
						if (mode_q != MODE_INSERT) begin
							fault_q <= FAULT_MISS;
						end else if (pool_full) begin
							fault_q <= FAULT_FULL;
						end else begin
							cur_q       <= next_free_q[NW-1:0];
							next_free_q <= next_free_q + FW'(1);
						end
					end else begin
						cur_q <= child_rdata;
					end
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					res_found_q  <= (fault_q == FAULT_NONE) && mode_q[MODE_PREFIX_BIT];
					res_status_q <= fault_status(fault_q);
					if (fault_q == FAULT_NONE && mode_q == MODE_SEARCH) begin
						state_q <= ST_MREAD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_MREAD: begin
					res_found_q <= mark_rdata;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_found_q  <= res_found_q;
						m_status_q <= res_status_q;
						cur_q      <= '0;
						fault_q    <= FAULT_NONE;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, m_status_q, m_found_q};

	`ASSERT_CHK(a_alloc_step,
		(state_q == ST_LOOK && child_rdata == '0 && mode_q == MODE_INSERT &&
			!pool_full) |=> (next_free_q == $past(next_free_q) + FW'(1)),
		"node allocation did not advance free pointer")

	`ASSERT_NEVER(a_cur_alloc, FW'(cur_q) >= next_free_q,
		"current node points past allocated pool")

	`ASSERT_CHK(a_look_clean, state_q == ST_LOOK |-> fault_q == FAULT_NONE,
		"child lookup issued for a faulted word")

	`ASSERT_CHK(a_emit_reset,
		(state_q == ST_EMIT && (!m_tvalid_q || m_tready)) |=>
			(m_tvalid_q && cur_q == '0 && fault_q == FAULT_NONE),
		"word state not returned to root after result")

endmodule

>>> sv/ltrie_ram.sv
// ----------------------------------------------------------------------------
// ltrie_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ltrie_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
